/* rtl/bcd_countdown_timer_serial_report_assert.svh */
// Assertion macros used by the timer core (bcdt_core).
`ifndef BCD_COUNTDOWN_TIMER_SERIAL_REPORT_ASSERT_SVH
`define BCD_COUNTDOWN_TIMER_SERIAL_REPORT_ASSERT_SVH

`ifndef SYNTHESIS
`define BCDT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BCDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BCDT_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCDT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/bcdt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bcdt_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int THRESH_W    = 16;
    localparam int CMP_W       = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;
    localparam int DIGIT_W     = 4;
    localparam int SEC_TENS_W  = 3;
    localparam int POS_W       = 3;
    localparam int CHAR_W      = 7;
    localparam int CFG_IDX_W   = 3;

    localparam logic [COUNT_WIDTH-1:0] TICK_MAX = '1;

    // item kinds
    localparam logic [1:0] KIND_POLL  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESET_MIN_TENS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESET_MIN_UNITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESET_SEC_TENS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESET_SEC_UNITS = 3'd4;

    localparam logic [THRESH_W-1:0]   RST_TICK_THRESHOLD   = 16'd1200;
    localparam logic [DIGIT_W-1:0]    RST_PRESET_MIN_TENS  = 4'd3;
    localparam logic [DIGIT_W-1:0]    RST_PRESET_MIN_UNITS = 4'd0;
    localparam logic [SEC_TENS_W-1:0] RST_PRESET_SEC_TENS  = 3'd0;
    localparam logic [DIGIT_W-1:0]    RST_PRESET_SEC_UNITS = 4'd0;

    localparam logic [DIGIT_W-1:0]    DIGIT_NINE     = 4'd9;
    localparam logic [SEC_TENS_W-1:0] SEC_TENS_FIVE  = 3'd5;
    localparam logic [POS_W-1:0]      SEND_LAST      = 3'd5;
    localparam logic [POS_W-1:0]      POS_MIN_TENS   = 3'd0;
    localparam logic [POS_W-1:0]      POS_MIN_UNITS  = 3'd1;
    localparam logic [POS_W-1:0]      POS_COLON      = 3'd2;
    localparam logic [POS_W-1:0]      POS_SEC_TENS   = 3'd3;
    localparam logic [POS_W-1:0]      POS_SEC_UNITS  = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_COLON   = 7'h3A;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0A;

    typedef enum logic [1:0] {
        MODE_STOPPED  = 2'd0,
        MODE_COUNTING = 2'd1,
        MODE_SENDING  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic       tick_elapsed;
        logic       tx_ready;
    } t_item;

    typedef struct packed {
        logic                  display_update;
        logic [DIGIT_W-1:0]    min_tens;
        logic [DIGIT_W-1:0]    min_units;
        logic [SEC_TENS_W-1:0] sec_tens;
        logic [DIGIT_W-1:0]    sec_units;
        logic                  second_beep;
        logic                  minute_sound;
        logic                  time_up;
        logic                  tx_valid;
        logic [CHAR_W-1:0]     tx_char;
        logic [1:0]            run_state;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [THRESH_W-1:0]   wdata;
    } t_cfg_wr;

endpackage
`default_nettype wire

/* rtl/bcd_countdown_timer_serial_report.sv */
// BCD MM:SS countdown timer with serial time report.
// Each item passes the input register, then the result register; a stalled
// output holds it in the input register.
// Throughput: one item per cycle unless the output stalls; the only loop is the state update.
// Reset (synchronous, active low): timer stopped at 00:00, tick count and
// report position cleared, registers at their default values, no item held.
`timescale 1ns / 1ps
`default_nettype none
module bcd_countdown_timer_serial_report (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,  // [0] tick_elapsed, [1] tx_ready
    input  wire logic [1:0]  i_s_axis_tuser,  // [1:0] kind
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [0] display_update, [4:1] min_tens, [8:5] min_units, [11:9] sec_tens,
    // [15:12] sec_units, [16] second_beep, [17] minute_sound, [18] time_up,
    // [19] tx_valid, [26:20] tx_char, [28:27] run_state
    output logic [31:0]      o_m_axis_tdata
);
    import bcdt_pkg::*;

    t_item   in_item, stage_item;
    t_result core_result, out_result;
    t_cfg_wr cfg_wr;
    logic    stage_valid, out_ready, core_fire;

    assign in_item.kind         = i_s_axis_tuser;
    assign in_item.tick_elapsed = i_s_axis_tdata[0];
    assign in_item.tx_ready     = i_s_axis_tdata[1];

    assign cfg_wr.we    = i_cfg_we;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.wdata = i_cfg_wdata;

    assign core_fire = stage_valid && out_ready;

    bcdt_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_ready (out_ready),
        .o_item  (stage_item)
    );

    bcdt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_fire   (core_fire),
        .i_item   (stage_item),
        .o_result (core_result)
    );

    bcdt_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid),
        .o_ready  (out_ready),
        .i_result (core_result),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_result)
    );

    assign o_m_axis_tdata = {
        3'b000,
        out_result.run_state,
        out_result.tx_char,
        out_result.tx_valid,
        out_result.time_up,
        out_result.minute_sound,
        out_result.second_beep,
        out_result.sec_units,
        out_result.sec_tens,
        out_result.min_units,
        out_result.min_tens,
        out_result.display_update
    };
endmodule
`default_nettype wire

/* rtl/bcdt_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
module bcdt_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire bcdt_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output bcdt_pkg::t_item     o_item
);
    import bcdt_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end
endmodule
`default_nettype wire

/* rtl/bcdt_core.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "bcd_countdown_timer_serial_report_assert.svh"
module bcdt_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bcdt_pkg::t_cfg_wr i_cfg,
    input  wire logic             i_fire,
    input  wire bcdt_pkg::t_item   i_item,
    output bcdt_pkg::t_result     o_result
);
    import bcdt_pkg::*;

    logic [THRESH_W-1:0]    r_thresh;
    logic [DIGIT_W-1:0]     r_pre_mt, r_pre_mu, r_pre_su;
    logic [SEC_TENS_W-1:0]  r_pre_st;

    t_mode                  r_mode, n_mode;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [DIGIT_W-1:0]     r_mt, r_mu, r_su, n_mt, n_mu, n_su;
    logic [SEC_TENS_W-1:0]  r_st, n_st;

    logic                   is_poll;
    logic [COUNT_WIDTH-1:0] tick_after;
    logic                   fire_dec;
    logic                   all_zero;
    logic                   send_char;
    logic                   last_char;
    logic [CHAR_W-1:0]      cur_char;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= RST_TICK_THRESHOLD;
            r_pre_mt <= RST_PRESET_MIN_TENS;
            r_pre_mu <= RST_PRESET_MIN_UNITS;
            r_pre_st <= RST_PRESET_SEC_TENS;
            r_pre_su <= RST_PRESET_SEC_UNITS;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                CFG_TICK_THRESHOLD:   r_thresh <= i_cfg.wdata;
                CFG_PRESET_MIN_TENS:  r_pre_mt <= i_cfg.wdata[DIGIT_W-1:0];
                CFG_PRESET_MIN_UNITS: r_pre_mu <= i_cfg.wdata[DIGIT_W-1:0];
                CFG_PRESET_SEC_TENS:  r_pre_st <= i_cfg.wdata[SEC_TENS_W-1:0];
                CFG_PRESET_SEC_UNITS: r_pre_su <= i_cfg.wdata[DIGIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign is_poll    = (i_item.kind == KIND_POLL);
    // saturating tick count, counted in every mode
    assign tick_after = (i_item.tick_elapsed && (r_tick != TICK_MAX)) ?
                        r_tick + 1'b1 : r_tick;
    assign fire_dec   = is_poll && (r_mode == MODE_COUNTING) &&
                        (CMP_W'(tick_after) >= CMP_W'(r_thresh));
    assign all_zero   = (r_su == '0) && (r_st == '0) && (r_mu == '0) && (r_mt == '0);
    assign send_char  = is_poll && (r_mode == MODE_SENDING) && i_item.tx_ready;
    assign last_char  = (r_pos >= SEND_LAST);

    // next state
    always_comb begin
        n_mode = r_mode;
        unique case (i_item.kind)
            KIND_START: n_mode = MODE_COUNTING;
            KIND_STOP:  n_mode = MODE_STOPPED;
            KIND_POLL: begin
                if (fire_dec) begin
                    n_mode = all_zero ? MODE_STOPPED : MODE_SENDING;
                end else if (send_char && last_char) begin
                    n_mode = MODE_COUNTING;
                end
            end
            default: n_mode = r_mode;
        endcase
    end

    always_comb begin
        case (r_pos)
            POS_MIN_TENS:  cur_char = CHAR_ZERO + CHAR_W'(r_mt);
            POS_MIN_UNITS: cur_char = CHAR_ZERO + CHAR_W'(r_mu);
            POS_COLON:     cur_char = CHAR_COLON;
            POS_SEC_TENS:  cur_char = CHAR_ZERO + CHAR_W'(r_st);
            POS_SEC_UNITS: cur_char = CHAR_ZERO + CHAR_W'(r_su);
            default:       cur_char = CHAR_NEWLINE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_pos  = r_pos;
        n_tick = r_tick;
        n_mt   = r_mt;
        n_mu   = r_mu;
        n_st   = r_st;
        n_su   = r_su;
        o_result = '0;
        case (i_item.kind)
            KIND_START: begin
                n_mt   = r_pre_mt;
                n_mu   = r_pre_mu;
                n_st   = r_pre_st;
                n_su   = r_pre_su;
                n_tick = '0;
                n_pos  = '0;
            end
            KIND_STOP: n_pos = '0;
            KIND_POLL: begin
                n_tick = tick_after;
                if (fire_dec) begin
                    n_tick = '0;
                    n_pos  = '0;
                    o_result.display_update = 1'b1;
                    if (r_su != '0) begin
                        n_su = r_su - 1'b1;
                        o_result.second_beep = 1'b1;
                    end else begin
                        n_su = DIGIT_NINE;
                        if (r_st != '0) begin
                            n_st = r_st - 1'b1;
                        end else begin
                            n_st = SEC_TENS_FIVE;
                            o_result.minute_sound = 1'b1;
                            if (r_mu != '0) begin
                                n_mu = r_mu - 1'b1;
                            end else begin
                                n_mu = DIGIT_NINE;
                                if (r_mt != '0) begin
                                    n_mt = r_mt - 1'b1;
                                end else begin
                                    // ran past 00:00
                                    n_mt = '0;
                                    n_mu = '0;
                                    n_st = '0;
                                    n_su = '0;
                                    o_result.time_up = 1'b1;
                                end
                            end
                        end
                    end
                end else if (send_char) begin
                    o_result.tx_valid = 1'b1;
                    o_result.tx_char  = cur_char;
                    n_pos = last_char ? '0 : r_pos + 1'b1;
                end
            end
            default: ;
        endcase
        o_result.min_tens  = n_mt;
        o_result.min_units = n_mu;
        o_result.sec_tens  = n_st;
        o_result.sec_units = n_su;
        o_result.run_state = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_STOPPED;
            r_pos  <= '0;
            r_tick <= '0;
            r_mt   <= '0;
            r_mu   <= '0;
            r_st   <= '0;
            r_su   <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_tick <= n_tick;
            r_mt   <= n_mt;
            r_mu   <= n_mu;
            r_st   <= n_st;
            r_su   <= n_su;
        end
    end

    `BCDT_ASSERT(a_pos_range, i_clk, i_rst_n, (r_pos <= SEND_LAST), "send position out of range")
    `BCDT_ASSERT(a_tx_only_sending, i_clk, i_rst_n, (o_result.tx_valid |-> (r_mode == MODE_SENDING)), "character sent outside report")
    `BCDT_ASSERT(a_timeup_stops, i_clk, i_rst_n, (o_result.time_up |-> (o_result.run_state == MODE_STOPPED) && o_result.minute_sound), "time up without stop")
    `BCDT_ASSERT(a_dec_clears_tick, i_clk, i_rst_n, ((i_fire && o_result.display_update) |=> (r_tick == '0) && (r_pos == '0)), "decrement left tick count or position")
endmodule
`default_nettype wire

/* rtl/bcdt_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
module bcdt_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire bcdt_pkg::t_result i_result,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output bcdt_pkg::t_result      o_result
);
    import bcdt_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end
endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;
    import bcdt_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 460;
    localparam int HOLD_POLLS = 20;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          val;
        t_item                it;
        bit                   typed;
        t_result              res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [0] tick_elapsed, [1] tx_ready
    logic [1:0]  i_s_axis_tuser;   // [1:0] kind
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // [0] display_update, [4:1] min_tens, [8:5] min_units, [11:9] sec_tens,
    // [15:12] sec_units, [16] second_beep, [17] minute_sound, [18] time_up,
    // [19] tx_valid, [26:20] tx_char, [28:27] run_state
    logic [31:0] o_m_axis_tdata;

    bcd_countdown_timer_serial_report dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // timer copy: registers
    logic [15:0]           thresh;
    logic [DIGIT_W-1:0]    pre_mt, pre_mu, pre_su;
    logic [SEC_TENS_W-1:0] pre_st;
    // timer copy: state
    t_mode                 timer_mode;
    logic [POS_W-1:0]      report_pos;
    logic [15:0]           tick_cnt;
    logic [DIGIT_W-1:0]    dig_mt, dig_mu, dig_su;
    logic [SEC_TENS_W-1:0] dig_st;

    t_result timer_outputs_due[$];
    t_row    plan[$];
    bit      no_idle;
    int      errors, n_items, n_results, n_decrements, n_time_ups, n_chars;
    int      quiet_cycles = 0;

    function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [15:0] val);
        case (idx)
            CFG_TICK_THRESHOLD:   thresh = val;
            CFG_PRESET_MIN_TENS:  pre_mt = val[DIGIT_W-1:0];
            CFG_PRESET_MIN_UNITS: pre_mu = val[DIGIT_W-1:0];
            CFG_PRESET_SEC_TENS:  pre_st = val[SEC_TENS_W-1:0];
            CFG_PRESET_SEC_UNITS: pre_su = val[DIGIT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_result advance_timer(input t_item it);
        t_result r;
        r = '0;
        case (it.kind)
            KIND_START: begin
                {dig_mt, dig_mu, dig_st, dig_su} = {pre_mt, pre_mu, pre_st, pre_su};
                tick_cnt   = '0;
                report_pos = '0;
                timer_mode = MODE_COUNTING;
            end
            KIND_STOP: begin
                timer_mode = MODE_STOPPED;
                report_pos = '0;
            end
            KIND_POLL: begin
                if (it.tick_elapsed && tick_cnt != TICK_MAX)
                    tick_cnt = tick_cnt + 1'b1;
                if (timer_mode == MODE_COUNTING) begin
                    if (tick_cnt >= thresh) begin
                        tick_cnt = '0;
                        r.display_update = 1'b1;
                        // borrow ripples from seconds units up to minutes tens
                        if (dig_su != 0) begin
                            dig_su = dig_su - 1'b1;
                            r.second_beep = 1'b1;
                        end else begin
                            dig_su = DIGIT_NINE;
                            if (dig_st != 0) begin
                                dig_st = dig_st - 1'b1;
                            end else begin
                                dig_st = SEC_TENS_FIVE;
                                r.minute_sound = 1'b1;
                                if (dig_mu != 0) begin
                                    dig_mu = dig_mu - 1'b1;
                                end else begin
                                    dig_mu = DIGIT_NINE;
                                    if (dig_mt != 0) begin
                                        dig_mt = dig_mt - 1'b1;
                                    end else begin
                                        {dig_mt, dig_mu, dig_st, dig_su} = '0;
                                        r.time_up = 1'b1;
                                    end
                                end
                            end
                        end
                        if (r.time_up) begin
                            timer_mode = MODE_STOPPED;
                        end else begin
                            timer_mode = MODE_SENDING;
                            report_pos = '0;
                        end
                    end
                end else if (timer_mode == MODE_SENDING && it.tx_ready) begin
                    r.tx_valid = 1'b1;
                    case (report_pos)
                        POS_MIN_TENS:  r.tx_char = CHAR_ZERO + {3'b0, dig_mt};
                        POS_MIN_UNITS: r.tx_char = CHAR_ZERO + {3'b0, dig_mu};
                        POS_COLON:     r.tx_char = CHAR_COLON;
                        POS_SEC_TENS:  r.tx_char = CHAR_ZERO + {4'b0, dig_st};
                        POS_SEC_UNITS: r.tx_char = CHAR_ZERO + {3'b0, dig_su};
                        default:       r.tx_char = CHAR_NEWLINE;
                    endcase
                    if (report_pos >= SEND_LAST) begin
                        report_pos = '0;
                        timer_mode = MODE_COUNTING;
                    end else begin
                        report_pos = report_pos + 1'b1;
                    end
                end
            end
            default: ;  // unused kind leaves everything alone
        endcase
        r.min_tens  = dig_mt;
        r.min_units = dig_mu;
        r.sec_tens  = dig_st;
        r.sec_units = dig_su;
        r.run_state = timer_mode;
        return r;
    endfunction

    function automatic t_result res_of(input int upd, input int mt, input int mu,
                                       input int st, input int su,
                                       input int beep, input int snd, input int up,
                                       input int txv, input int ch, input t_mode m);
        t_result r;
        r = '{1'(upd), 4'(mt), 4'(mu), 3'(st), 4'(su), 1'(beep), 1'(snd), 1'(up),
              1'(txv), 7'(ch), m};
        return r;
    endfunction

    function automatic t_row item_row(input logic [1:0] kind, input logic tick, input logic rdy);
        t_row r;
        r = '{1'b0, '0, '0, '{kind, tick, rdy}, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row check_row(input logic [1:0] kind, input logic tick,
                                       input logic rdy, input t_result res);
        t_row r;
        r = '{1'b0, '0, '0, '{kind, tick, rdy}, 1'b1, res};
        return r;
    endfunction

    function automatic t_row reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        t_row r;
        r = '{1'b1, idx, val, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("upd=%0d %0d%0d:%0d%0d beep=%0d snd=%0d up=%0d txv=%0d chr=%02h st=%0d",
                         r.display_update, r.min_tens, r.min_units, r.sec_tens, r.sec_units,
                         r.second_beep, r.minute_sound, r.time_up, r.tx_valid, r.tx_char,
                         r.run_state);
    endfunction

    task automatic send_item(input t_item it, input bit typed = 1'b0, input t_result fixed = '0);
        t_result pred;
        while (!no_idle && $urandom_range(99) < 25) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, it.tx_ready, it.tick_elapsed};
        i_s_axis_tuser  <= it.kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = advance_timer(it);
        timer_outputs_due.push_back(typed ? fixed : pred);
        n_items++;
        n_decrements += pred.display_update;
        n_time_ups   += pred.time_up;
        n_chars      += pred.tx_valid;
    endtask

    task automatic await_quiet();
        i_s_axis_tvalid <= 1'b0;
        while (timer_outputs_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        load_register(idx, val);
    endtask

    task automatic check_output(input logic [31:0] d);
        t_result got, want;
        string   bad;
        got = '{d[0], d[4:1], d[8:5], d[11:9], d[15:12], d[16], d[17], d[18], d[19],
                d[26:20], d[28:27]};
        n_results++;
        if (timer_outputs_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("%0t: output with nothing outstanding: %s", $realtime, show(got));
        end else begin
            want = timer_outputs_due.pop_front();
            bad = "";
            if (got.display_update !== want.display_update) bad = {bad, " display_update"};
            if (got.min_tens     !== want.min_tens)     bad = {bad, " min_tens"};
            if (got.min_units    !== want.min_units)    bad = {bad, " min_units"};
            if (got.sec_tens     !== want.sec_tens)     bad = {bad, " sec_tens"};
            if (got.sec_units    !== want.sec_units)    bad = {bad, " sec_units"};
            if (got.second_beep  !== want.second_beep)  bad = {bad, " second_beep"};
            if (got.minute_sound !== want.minute_sound) bad = {bad, " minute_sound"};
            if (got.time_up      !== want.time_up)      bad = {bad, " time_up"};
            if (got.tx_valid     !== want.tx_valid)     bad = {bad, " tx_valid"};
            if (got.tx_char      !== want.tx_char)      bad = {bad, " tx_char"};
            if (got.run_state    !== want.run_state)    bad = {bad, " run_state"};
            if (bad != "") begin
                errors++;
                if (errors <= 10)
                    $display("%0t: output %0d differs in%s\n  exp %s\n  got %s",
                             $realtime, n_results, bad, show(want), show(got));
            end
        end
    endtask

    // receiver: random backpressure unless no_idle is set, checks every output item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_output(o_m_axis_tdata);
            i_m_axis_tready <= no_idle || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("bcd_countdown_timer_serial_report: mismatch");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int    n_rand, phase, len, pick;
        t_item it;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= KIND_POLL;
        no_idle      = 1'b0;
        errors       = 0;
        n_items      = 0;
        n_results    = 0;
        n_decrements = 0;
        n_time_ups   = 0;
        n_chars      = 0;

        thresh = RST_TICK_THRESHOLD;
        pre_mt = RST_PRESET_MIN_TENS;
        pre_mu = RST_PRESET_MIN_UNITS;
        pre_st = RST_PRESET_SEC_TENS;
        pre_su = RST_PRESET_SEC_UNITS;
        timer_mode = MODE_STOPPED;
        report_pos = '0;
        tick_cnt   = '0;
        {dig_mt, dig_mu, dig_st, dig_su} = '0;

        // directed: reset view, ignored kinds, one-second run to time up, wide presets
        plan.push_back(check_row(KIND_POLL, 1'b0, 1'b0,
                                 res_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_STOPPED)));
        plan.push_back(check_row(KIND_UNUSED, 1'b1, 1'b1,
                                 res_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_STOPPED)));
        plan.push_back(check_row(KIND_STOP, 1'b1, 1'b1,
                                 res_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_STOPPED)));
        plan.push_back(check_row(KIND_START, 1'b1, 1'b1,
                                 res_of(0, 3, 0, 0, 0, 0, 0, 0, 0, 0, MODE_COUNTING)));
        plan.push_back(item_row(KIND_POLL, 1'b1, 1'b1));
        plan.push_back(reg_row(CFG_TICK_THRESHOLD, 16'h0000));
        plan.push_back(reg_row(CFG_PRESET_MIN_TENS, 16'hFFF0));  // upper bits dropped
        plan.push_back(reg_row(CFG_PRESET_MIN_UNITS, 16'h0000));
        plan.push_back(reg_row(CFG_PRESET_SEC_TENS, 16'hFFF8));
        plan.push_back(reg_row(CFG_PRESET_SEC_UNITS, 16'h0001));
        plan.push_back(reg_row(CFG_SPARE, 16'hFFFF));            // no register there
        plan.push_back(item_row(KIND_START, 1'b0, 1'b0));
        plan.push_back(item_row(KIND_POLL, 1'b0, 1'b0));          // decrement, no char
        plan.push_back(item_row(KIND_POLL, 1'b0, 1'b0));          // transmitter busy
        repeat (6) plan.push_back(item_row(KIND_POLL, 1'b1, 1'b1));
        plan.push_back(check_row(KIND_POLL, 1'b0, 1'b1,
                                 res_of(1, 0, 0, 0, 0, 0, 1, 1, 0, 0, MODE_STOPPED)));
        plan.push_back(check_row(KIND_POLL, 1'b1, 1'b1,
                                 res_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_STOPPED)));
        plan.push_back(reg_row(CFG_TICK_THRESHOLD, 16'h0002));
        plan.push_back(reg_row(CFG_PRESET_MIN_TENS, 16'h000F));
        plan.push_back(reg_row(CFG_PRESET_MIN_UNITS, 16'h000F));
        plan.push_back(reg_row(CFG_PRESET_SEC_TENS, 16'h0007));
        plan.push_back(reg_row(CFG_PRESET_SEC_UNITS, 16'h000F));
        plan.push_back(item_row(KIND_START, 1'b1, 1'b0));
        plan.push_back(item_row(KIND_POLL, 1'b1, 1'b0));
        plan.push_back(item_row(KIND_POLL, 1'b1, 1'b0));
        plan.push_back(item_row(KIND_POLL, 1'b0, 1'b1));
        plan.push_back(item_row(KIND_POLL, 1'b1, 1'b1));
        plan.push_back(item_row(KIND_STOP, 1'b0, 1'b1));          // stop mid-report
        plan.push_back(item_row(KIND_START, 1'b0, 1'b0));
        plan.push_back(item_row(KIND_POLL, 1'b1, 1'b1));
        plan.push_back(item_row(KIND_POLL, 1'b1, 1'b1));
        plan.push_back(item_row(KIND_UNUSED, 1'b0, 1'b0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                await_quiet();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_item(plan[i].it, plan[i].typed, plan[i].res);
            end
        end

        // random phases: new settings, a start, then mostly polls
        n_rand = 0;
        phase  = 0;
        while (n_rand < RANDOM_ITEMS) begin
            await_quiet();
            no_idle = (phase == 2 || phase == 3);
            pick = $urandom_range(99);
            write_reg(CFG_TICK_THRESHOLD, 16'((pick < 60) ? $urandom_range(3) :
                                              (pick < 85) ? $urandom_range(20, 4) :
                                                            $urandom_range(65535)));
            write_reg(CFG_PRESET_MIN_TENS, ($urandom_range(7) == 0) ? 16'($urandom) : 16'd0);
            pick = $urandom_range(7);
            write_reg(CFG_PRESET_MIN_UNITS, (pick < 2) ? 16'd1 :
                                            (pick == 2) ? 16'($urandom) : 16'd0);
            write_reg(CFG_PRESET_SEC_TENS, ($urandom_range(3) == 0) ? 16'($urandom) :
                                           16'($urandom_range(1)));
            write_reg(CFG_PRESET_SEC_UNITS, ($urandom_range(7) == 0) ? 16'($urandom) :
                                            16'($urandom_range(9)));
            if ($urandom_range(3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_LAST_INDEX, CFG_SPARE)),
                          16'($urandom));
            send_item('{KIND_START, 1'($urandom), 1'($urandom)});
            n_rand++;
            len = $urandom_range(120, 40);
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(99);
                it.kind = (pick < 2) ? KIND_STOP : (pick < 4) ? KIND_UNUSED :
                          (pick < 6) ? KIND_START : KIND_POLL;
                it.tick_elapsed = ($urandom_range(99) < 75);
                it.tx_ready     = ($urandom_range(99) < 65);
                send_item(it);
                n_rand++;
            end
            phase++;
        end

        // ticks keep counting while a report is held open
        await_quiet();
        no_idle = 1'b0;
        write_reg(CFG_TICK_THRESHOLD, 16'd1);
        write_reg(CFG_PRESET_MIN_TENS, 16'd0);
        write_reg(CFG_PRESET_MIN_UNITS, 16'd0);
        write_reg(CFG_PRESET_SEC_TENS, 16'd0);
        write_reg(CFG_PRESET_SEC_UNITS, 16'd2);
        send_item('{KIND_START, 1'b0, 1'b0});
        send_item('{KIND_POLL, 1'b1, 1'b0});
        repeat (HOLD_POLLS) send_item('{KIND_POLL, 1'b1, 1'b0});
        await_quiet();
        write_reg(CFG_TICK_THRESHOLD, 16'(HOLD_POLLS));
        repeat (6) send_item('{KIND_POLL, 1'b0, 1'b1});
        // the ticks piled up during the report reach the threshold at once
        repeat (4) send_item('{KIND_POLL, 1'b0, 1'b1});

        i_s_axis_tvalid <= 1'b0;
        while (timer_outputs_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("ran %0d items: %0d one-second steps, %0d time-ups, %0d report chars",
                 n_items, n_decrements, n_time_ups, n_chars);
        $display("checked %0d outputs, %0d mismatches", n_results, errors);
        if (errors == 0 && timer_outputs_due.size() == 0) begin
            $display("bcd_countdown_timer_serial_report: match");
        end else begin
            $display("bcd_countdown_timer_serial_report: mismatch");
        end
        $finish;
    end
endmodule
